>>> sv/k_nearest_neighbour_select_top_assert.svh
// Assertion macros for the nearest neighbour select block.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef K_NEAREST_NEIGHBOUR_SELECT_TOP_ASSERT_SVH
`define K_NEAREST_NEIGHBOUR_SELECT_TOP_ASSERT_SVH

// same-cycle implication
`define KNNS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("knns check failed");

// next-cycle implication
`define KNNS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("knns check failed");

`endif

>>> sv/knns_pkg.sv
// Shared constants for the nearest neighbour select block.
// No dependencies.
package knns_pkg;

	localparam int unsigned NEAR_SLOTS_DEF = 4;
	localparam int unsigned PREV_SUBSETS = 65536;
	localparam int unsigned IDX_LIMIT_W = 21;

	localparam int unsigned COORD_W = 14;
	localparam int unsigned INDEX_W = 16;
	localparam int unsigned SQ_W = 2 * COORD_W;
	localparam int unsigned DIST_W = 30;

	localparam int unsigned RANK_W = 2;
	localparam int unsigned COUNT_W = 3;

	localparam int unsigned S_TDATA_W = 72;
	localparam int unsigned M_TDATA_W = 24;

endpackage

>>> sv/k_nearest_neighbour_select_top.sv
// Top level of the nearest neighbour select block: distance, sorted insert, output bank.
// Depends on knns_pkg and k_nearest_neighbour_select_top_assert.svh.
//
//  channel | dir | tdata                                   | tuser      | tlast
//  s_*     | in  | query_x,query_y,cand_x,cand_y,cand_index | cand_valid | run_end
//  m_*     | out | neigh_index,neigh_rank,neigh_count        | none_found | result_last
//
// One candidate is taken per cycle unless stalled; the sorted-list insert is combinational.
// Two register stages (capture, then subtract/square) precede the add, the sorted insert and the output bank.
// A run end emits max(1, fill) results from a separate bank, one per cycle while m_tready is high.
// Input stalls only when a run end reaches the insert stage while the bank still holds results.
// Reset clears all valid bits and the fill marks; no clearing pass.
`include "k_nearest_neighbour_select_top_assert.svh"

module k_nearest_neighbour_select_top #(
	parameter int unsigned NEAR_SLOTS = knns_pkg::NEAR_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// query_x[13:0], query_y[27:14], cand_x[41:28], cand_y[55:42], cand_index[71:56]
	input  logic [knns_pkg::S_TDATA_W-1:0]    s_tdata,
	// cand_valid
	input  logic                              s_tuser,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// neigh_index[15:0], neigh_rank[17:16], neigh_count[20:18], zero[23:21]
	output logic [knns_pkg::M_TDATA_W-1:0]    m_tdata,
	// none_found
	output logic                              m_tuser,
	output logic                              m_tlast
);
	import knns_pkg::*;

	localparam int unsigned PW = (NEAR_SLOTS > 1) ? $clog2(NEAR_SLOTS) : 1;
	localparam int unsigned CW = $clog2(NEAR_SLOTS + 1);

	logic               adv;
	logic               stall;
	logic               bank_free;
	logic               load;

	logic               valid_s1;
	logic [COORD_W-1:0] qx_s1, qy_s1, cx_s1, cy_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic               ok_s1;
	logic               last_s1;

	logic [COORD_W-1:0] dx, dy;

	logic               valid_s2;
	logic [SQ_W-1:0]    sqx_s2, sqy_s2;
	logic [INDEX_W-1:0] idx_s2;
	logic               ok_s2;
	logic               last_s2;

	logic [DIST_W-1:0]     dist_new;
	logic [DIST_W-1:0]     dist_q [NEAR_SLOTS];
	logic [INDEX_W-1:0]    idx_q [NEAR_SLOTS];
	logic [NEAR_SLOTS-1:0] filled_q;

	logic [NEAR_SLOTS-1:0] keep;
	logic [DIST_W-1:0]     dist_nx [NEAR_SLOTS];
	logic [INDEX_W-1:0]    idx_nx [NEAR_SLOTS];
	logic [NEAR_SLOTS-1:0] filled_nx;
	logic [CW-1:0]         fill_cnt;

	logic [INDEX_W-1:0] bank_idx_q [NEAR_SLOTS];
	logic [CW-1:0]      bank_n_q;
	logic [PW-1:0]      ptr_q;
	logic               out_valid_q;
	logic [CW-1:0]      ptr_inc;
	logic               none_found;
	logic [PW+1:0]      rank_ext;
	logic [CW+2:0]      cnt_ext;

	// handshake and stall
	assign bank_free = !out_valid_q || (m_tready && m_tlast);
	assign stall     = valid_s2 && last_s2 && !bank_free;
	assign adv       = !stall;
	assign s_tready  = adv;
	assign load      = adv && valid_s2 && last_s2;

	// stage 1: capture the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s1   <= s_tdata[13:0];
			qy_s1   <= s_tdata[27:14];
			cx_s1   <= s_tdata[41:28];
			cy_s1   <= s_tdata[55:42];
			idx_s1  <= s_tdata[71:56];
			ok_s1   <= s_tuser && ({5'd0, s_tdata[71:56]} < IDX_LIMIT_W'(PREV_SUBSETS));
			last_s1 <= s_tlast;
		end
	end

	// stage 2: squared differences
	assign dx = (cx_s1 > qx_s1) ? (cx_s1 - qx_s1) : (qx_s1 - cx_s1);
	assign dy = (cy_s1 > qy_s1) ? (cy_s1 - qy_s1) : (qy_s1 - cy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2  <= SQ_W'(dx) * SQ_W'(dx);
			sqy_s2  <= SQ_W'(dy) * SQ_W'(dy);
			idx_s2  <= idx_s1;
			ok_s2   <= ok_s1;
			last_s2 <= last_s1;
		end
	end

	// sorted insert; equal distances keep the earlier entry ahead
	assign dist_new = DIST_W'(sqx_s2) + DIST_W'(sqy_s2);

	always_comb begin
		for (int i = 0; i < NEAR_SLOTS; i++) begin
			keep[i] = filled_q[i] && (dist_q[i] <= dist_new);
		end
		if (!ok_s2 || keep[0]) begin
			dist_nx[0] = dist_q[0];
			idx_nx[0]  = idx_q[0];
		end else begin
			dist_nx[0] = dist_new;
			idx_nx[0]  = idx_s2;
		end
		filled_nx[0] = filled_q[0] || ok_s2;
		for (int i = 1; i < NEAR_SLOTS; i++) begin
			if (!ok_s2 || keep[i]) begin
				dist_nx[i] = dist_q[i];
				idx_nx[i]  = idx_q[i];
			end else if (keep[i-1]) begin
				dist_nx[i] = dist_new;
				idx_nx[i]  = idx_s2;
			end else begin
				dist_nx[i] = dist_q[i-1];
				idx_nx[i]  = idx_q[i-1];
			end
			filled_nx[i] = filled_q[i] || (ok_s2 && filled_q[i-1]);
		end
		fill_cnt = '0;
		for (int i = 0; i < NEAR_SLOTS; i++) begin
			fill_cnt = fill_cnt + CW'(filled_nx[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (adv && valid_s2) begin
			filled_q <= last_s2 ? '0 : filled_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			for (int i = 0; i < NEAR_SLOTS; i++) begin
				dist_q[i] <= dist_nx[i];
				idx_q[i]  <= idx_nx[i];
			end
		end
	end

	// output bank
	assign ptr_inc = CW'(ptr_q) + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ptr_q       <= '0;
			bank_n_q    <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			ptr_q       <= '0;
			bank_n_q    <= fill_cnt;
		end else if (out_valid_q && m_tready) begin
			if (m_tlast) begin
				out_valid_q <= 1'b0;
			end else begin
				ptr_q <= ptr_inc[PW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NEAR_SLOTS; i++) begin
				bank_idx_q[i] <= idx_nx[i];
			end
		end
	end

	assign none_found = (bank_n_q == '0);
	assign rank_ext   = {2'b00, ptr_q};
	assign cnt_ext    = {3'b000, bank_n_q};

	assign m_tvalid = out_valid_q;
	assign m_tuser  = none_found;
	assign m_tlast  = none_found || (ptr_inc == bank_n_q);
	assign m_tdata  = {3'b000, cnt_ext[COUNT_W-1:0], rank_ext[RANK_W-1:0],
		none_found ? INDEX_W'(0) : bank_idx_q[ptr_q]};

	`KNNS_ASSERT_NOW(a_stall_needs_bank, stall, out_valid_q)
	`KNNS_ASSERT_NEXT(a_load_starts_bank, load, m_tvalid && (ptr_q == '0))
	`KNNS_ASSERT_NOW(a_fill_prefix, 1'b1, ((filled_q & (filled_q + 1'b1)) == '0))

endmodule
